>>> hw/rtl/gh_pkg.sv
package gh_pkg;

  // grid geometry
  localparam int unsigned COL_W    = 8;               // column index bits (256 columns)
  localparam int unsigned ROW_W    = 10;              // row index bits (1024 rows)
  localparam int unsigned COLS_W   = 9;               // grid_cols register width
  localparam int unsigned ROWS_W   = 11;              // grid_rows register width
  localparam int unsigned SMP_W    = 16;              // sample width
  localparam int unsigned CFG_W    = 11;              // config data width
  localparam int unsigned SUM_W    = 21;              // signed sum of 16 samples
  localparam int unsigned MAG_W    = 20;              // magnitude of that sum
  localparam int unsigned CNT_W    = 5;               // tap count 0..16
  localparam int unsigned ADDR_W   = COL_W + 2;       // line store address
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = 2;

  localparam logic [COLS_W-1:0] MAX_COLS = 9'd256;
  localparam logic [ROWS_W-1:0] MAX_ROWS = 11'd1024;

  // register indexes
  localparam logic REG_GRID_COLS = 1'b0;
  localparam logic REG_GRID_ROWS = 1'b1;

  // effective grid size
  typedef struct packed {
    logic [COLS_W-1:0] cols;
    logic [ROWS_W-1:0] rows;
  } grid_t;

  // one accepted sample with the results it triggers
  // jobs[0] (r-1,c-1), jobs[1] (r-1,c), jobs[2] (r,c-1), jobs[3] (r,c)
  typedef struct packed {
    logic signed [SMP_W-1:0] val;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic [3:0]              jobs;
  } entry_t;

endpackage

>>> hw/rtl/gh_fifo.sv
module gh_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gh_pkg::entry_t push_data,
  output logic           full,
  input  logic           pop,
  output gh_pkg::entry_t pop_data,
  output logic           empty
);
  import gh_pkg::*;

  entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full     = (fill == (QPTR_W+1)'(QDEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

>>> hw/rtl/gh_front.sv
module gh_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [gh_pkg::CFG_W-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [15:0]        height_sample,
  input  logic                      q_full,
  output logic                      q_push,
  output gh_pkg::entry_t            q_data,
  output gh_pkg::grid_t             grid
);
  import gh_pkg::*;

  logic [COLS_W-1:0] grid_cols;
  logic [ROWS_W-1:0] grid_rows;
  logic [ROW_W-1:0]  row_pos;
  logic [COL_W-1:0]  col_pos;
  logic              end_row;
  logic              last_row;
  logic              not_first_col;
  logic              not_first_row;
  logic signed [SMP_W-1:0] neg_val;

  // effective size: zero acts as one, above the maximum clamps
  always_comb begin
    if (grid_cols == '0)          grid.cols = COLS_W'(1);
    else if (grid_cols > MAX_COLS) grid.cols = MAX_COLS;
    else                           grid.cols = grid_cols;
    if (grid_rows == '0)          grid.rows = ROWS_W'(1);
    else if (grid_rows > MAX_ROWS) grid.rows = MAX_ROWS;
    else                           grid.rows = grid_rows;
  end

  // negate with saturation of the most negative code
  assign neg_val = (height_sample == {1'b1, {(SMP_W-1){1'b0}}}) ?
                   {1'b0, {(SMP_W-1){1'b1}}} : -height_sample;

  assign end_row       = (({1'b0, col_pos} + COLS_W'(1)) >= grid.cols);
  assign last_row      = (({1'b0, row_pos} + ROWS_W'(1)) >= grid.rows);
  assign not_first_col = (col_pos != '0);
  assign not_first_row = (row_pos != '0);

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // classify the sample by the results it completes
  always_comb begin
    q_data.val     = neg_val;
    q_data.row     = row_pos;
    q_data.col     = col_pos;
    q_data.jobs[0] = not_first_row && not_first_col;
    q_data.jobs[1] = not_first_row && end_row;
    q_data.jobs[2] = last_row && not_first_col;
    q_data.jobs[3] = last_row && end_row;
  end

  // config registers and raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= COLS_W'(256);
      grid_rows <= ROWS_W'(256);
      row_pos   <= '0;
      col_pos   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_COLS: grid_cols <= cfg_data[COLS_W-1:0];
        REG_GRID_ROWS: grid_rows <= cfg_data[ROWS_W-1:0];
        default: ;
      endcase
      row_pos <= '0;
      col_pos <= '0;
    end else if (q_push) begin
      if (end_row) begin
        col_pos <= '0;
        row_pos <= last_row ? '0 : row_pos + 1'b1;
      end else begin
        col_pos <= col_pos + 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/gh_div.sv
module gh_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gh_pkg::MAG_W-1:0]   dividend,
  input  logic [gh_pkg::CNT_W-1:0]   divisor,
  output logic [gh_pkg::MAG_W-1:0]   quotient,
  output logic                       done
);
  import gh_pkg::*;

  logic [CNT_W:0]   rem;
  logic [CNT_W:0]   trial;
  logic [CNT_W-1:0] dsor;
  logic [CNT_W-1:0] steps;
  logic             busy;

  assign trial = {rem[CNT_W-1:0], quotient[MAG_W-1]};

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        rem      <= '0;
        dsor     <= divisor;
        quotient <= dividend;
        steps    <= CNT_W'(MAG_W);
      end else if (busy) begin
        if (trial >= {1'b0, dsor}) begin
          rem      <= trial - {1'b0, dsor};
          quotient <= {quotient[MAG_W-2:0], 1'b1};
        end else begin
          rem      <= trial;
          quotient <= {quotient[MAG_W-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/gh_back.sv
module gh_back (
  input  logic                 clk,
  input  logic                 rst,
  input  gh_pkg::grid_t        grid,
  input  logic                 q_empty,
  input  gh_pkg::entry_t       q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   filled_height,
  output logic [9:0]           out_row,
  output logic [7:0]           out_col,
  output logic                 was_hole,
  output logic                 last_of_run
);
  import gh_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WRITE = 9'b000000010,
    S_SEL   = 9'b000000100,
    S_CCHK  = 9'b000001000,
    S_TAPS  = 9'b000010000,
    S_DSTRT = 9'b000100000,
    S_DWAIT = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  logic signed [SMP_W-1:0] store [4 << COL_W];
  logic signed [SMP_W-1:0] rdata;
  logic [ADDR_W-1:0]       rd_addr;

  entry_t            ent;
  logic [3:0]        jobs_left;
  logic [1:0]        sel;
  logic [ROW_W-1:0]  pick_row;
  logic [COL_W-1:0]  pick_col;
  logic [ROW_W-1:0]  job_row;
  logic [COL_W-1:0]  job_col;
  logic              job_last;
  logic [CNT_W-1:0]  k;
  logic [ROW_W+1:0]  trow;
  logic [COL_W+1:0]  tcol;
  logic              tap_ok;
  logic              pend;
  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0]  cnt;
  logic              sum_neg;
  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  quo;
  logic              div_start;
  logic              div_done;

  assign q_pop = (state == S_IDLE) && !q_empty;

  // lowest pending result first
  always_comb begin
    priority if (jobs_left[0]) sel = 2'd0;
    else if (jobs_left[1])     sel = 2'd1;
    else if (jobs_left[2])     sel = 2'd2;
    else                       sel = 2'd3;
    pick_row = sel[1] ? ent.row : ent.row - 1'b1;
    pick_col = sel[0] ? ent.col : ent.col - 1'b1;
  end

  // window tap k: rows job_row-2+k[3:2], columns job_col-2+k[1:0]
  always_comb begin
    trow   = {2'b00, job_row} + {{ROW_W{1'b0}}, k[3:2]} - (ROW_W+2)'(2);
    tcol   = {2'b00, job_col} + {{COL_W{1'b0}}, k[1:0]} - (COL_W+2)'(2);
    tap_ok = !k[CNT_W-1] && !trow[ROW_W+1] && !tcol[COL_W+1] &&
             (trow < {1'b0, grid.rows}) && (tcol < {1'b0, grid.cols});
  end

  // read address: center in select, taps while summing
  always_comb begin
    if (state == S_SEL) rd_addr = {pick_row[1:0], pick_col};
    else                rd_addr = {trow[1:0], tcol[COL_W-1:0]};
  end

  // line store, four rows addressed by row mod 4
  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      store[{ent.row[1:0], ent.col}] <= ent.val;
    end
    rdata <= store[rd_addr];
  end

  assign sum_neg   = sum[SUM_W-1];
  assign mag       = sum_neg ? MAG_W'(-sum) : MAG_W'(sum);
  assign div_start = (state == S_DSTRT) && (cnt != '0);

  gh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (cnt),
    .quotient (quo),
    .done     (div_done)
  );

  assign out_valid = (state == S_OUT);

  // result sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            ent   <= q_data;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          jobs_left <= ent.jobs;
          state     <= S_SEL;
        end
        S_SEL: begin
          if (jobs_left == '0) begin
            state <= S_IDLE;
          end else begin
            job_row   <= pick_row;
            job_col   <= pick_col;
            jobs_left <= jobs_left & ~(4'b0001 << sel);
            job_last  <= ((jobs_left & ~(4'b0001 << sel)) == '0);
            state     <= S_CCHK;
          end
        end
        S_CCHK: begin
          if (rdata != '0) begin
            filled_height <= rdata;
            was_hole      <= 1'b0;
            state         <= S_OUT;
          end else begin
            was_hole <= 1'b1;
            k        <= '0;
            sum      <= '0;
            cnt      <= '0;
            pend     <= 1'b0;
            state    <= S_TAPS;
          end
        end
        S_TAPS: begin
          // data of the previous tap arrives as the next is addressed
          if (pend && rdata != '0) begin
            sum <= sum + SUM_W'(rdata);
            cnt <= cnt + 1'b1;
          end
          pend <= tap_ok;
          k    <= k + 1'b1;
          if (k[CNT_W-1]) state <= S_DSTRT;
        end
        S_DSTRT: begin
          pend <= 1'b0;
          if (cnt == '0) begin
            filled_height <= '0;
            state         <= S_OUT;
          end else begin
            state <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (div_done) begin
            filled_height <= sum_neg ? -quo[SMP_W-1:0] : quo[SMP_W-1:0];
            state         <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_DONE;
        end
        S_DONE: begin
          state <= S_SEL;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_row     = job_row;
  assign out_col     = job_col;
  assign last_of_run = job_last;

  // checks
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("pop from empty queue");
  a_pass_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !was_hole |-> filled_height != '0) else $error("pass-through of zero");
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DWAIT) else $error("divider done outside wait");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DSTRT |-> cnt <= CNT_W'(16)) else $error("tap count overflow");

endmodule

>>> hw/rtl/grid_hole_fill_neighbor_mean_core.sv
// Hole filler for a raster height grid: samples enter one per transfer in raster order and
// are negated; nonzero values pass out unchanged, zeros are replaced by the truncated mean
// of the nonzero samples in the 4x4 window (rows r-2..r+1, columns c-2..c+1) clipped at the
// grid edges. Results carry row and column and come out as soon as their window is
// complete, up to four per input; last_of_run marks the final one. A four-entry queue
// decouples intake from the result sequencer, so short bursts are taken one per cycle.
// For each input the sequencer writes the sample to the line store; per result it then
// reads the center: a kept sample goes straight out, while a hole takes 17 line-store
// reads, one per cycle, and a 20-step divider, or yields zero if its window has no nonzero
// sample; stalls hold it. Writing grid_cols or grid_rows restarts the frame at row 0.
module grid_hole_fill_neighbor_mean_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [gh_pkg::CFG_W-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [15:0]        height_sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [15:0]        filled_height,
  output logic [9:0]                out_row,
  output logic [7:0]                out_col,
  output logic                      was_hole,
  output logic                      last_of_run
);
  import gh_pkg::*;

  grid_t  grid;
  entry_t push_data;
  entry_t pop_data;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;

  gh_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .height_sample (height_sample),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (push_data),
    .grid          (grid)
  );

  gh_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  gh_back u_back (
    .clk           (clk),
    .rst           (rst),
    .grid          (grid),
    .q_empty       (q_empty),
    .q_data        (pop_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .filled_height (filled_height),
    .out_row       (out_row),
    .out_col       (out_col),
    .was_hole      (was_hole),
    .last_of_run   (last_of_run)
  );

endmodule
